### hdl/ama_pkg.sv
// Shared definitions for the moving average block: parameter defaults and the
// status bundle of the serial divider. No dependencies.
`default_nettype none
package ama_pkg;

  localparam int DEF_WINDOW      = 32;
  localparam int DEF_SAMPLE_BITS = 10;

  // Divider status as seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### hdl/ama_div.sv
// Restoring divider, one quotient bit per cycle, for the moving average block.
// Depends on ama_pkg for the status bundle.
`default_nettype none
module ama_div #(
  parameter int NUM_BITS = 15,
  parameter int DEN_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_BITS-1:0]   num,
  input  logic [DEN_BITS-1:0]   den,
  output logic [NUM_BITS-1:0]   quot,
  output ama_pkg::div_stat_t    stat
);
  import ama_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] dsr;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;

  logic [DEN_BITS:0]   trial;
  logic                fits;
  logic [DEN_BITS:0]   diff;

  // Bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, q[NUM_BITS-1]};
    fits  = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend and quotient share one shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      q   <= {q[NUM_BITS-2:0], fits};
      rem <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    end
  end

  assign quot      = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

### hdl/adc_moving_average_with_warmup.sv
// Top level of the converter moving average with warm-up.
// Depends on ama_pkg and the serial divider ama_div.
`default_nettype none
// Boxcar average of the last WINDOW samples. Until WINDOW samples have been
// taken, the result is the mean of the samples seen so far; division
// truncates. One item is in work at a time: after the item is taken, the
// ring read and sum update come first, then the bit-serial divider, which
// produces one quotient bit per cycle over the SUM_BITS-bit running sum,
// then its done flag. The next item is taken in the cycle after the result is
// loaded at the earliest, and a finished quotient that waits behind a stalled
// result holds it off further. The result register parts the two sides, so a
// new item is taken while a result still waits.
module adc_moving_average_with_warmup #(
  parameter int WINDOW      = ama_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = ama_pkg::DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] average
);
  import ama_pkg::*;

  localparam int POS_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_BITS   = SAMPLE_BITS + POS_BITS;
  localparam int DEN_BITS   = POS_BITS + 1;
  localparam int MAX_SAMPLE = (1 << SAMPLE_BITS) - 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_UPDATE = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_LOAD   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SAMPLE_BITS-1:0] ring [WINDOW];
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SAMPLE_BITS-1:0] new_sample;
  logic [SUM_BITS-1:0]    running_sum;
  logic [SUM_BITS-1:0]    running_sum_next;
  logic [POS_BITS-1:0]    pos;
  logic                   warming_up;
  logic [DEN_BITS-1:0]    divisor;

  logic                   div_start;
  logic [SUM_BITS-1:0]    quot;
  div_stat_t              div_stat;

  logic                   in_take;
  logic                   out_room;
  logic                   out_load;
  logic                   last_slot;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_room  = !out_valid || !out_stall;
  assign last_slot = (pos == POS_BITS'(WINDOW - 1));
  assign div_start = (state == ST_UPDATE);

  always_comb begin
    running_sum_next = running_sum + SUM_BITS'(new_sample);
    if (!warming_up) begin
      running_sum_next = running_sum_next - SUM_BITS'(old_sample);
    end
    divisor = warming_up ? (DEN_BITS'(pos) + 1'b1) : DEN_BITS'(WINDOW);
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_take) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (out_room) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (out_room) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_sum <= '0;
      pos         <= '0;
      warming_up  <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_UPDATE) begin
        running_sum <= running_sum_next;
        pos         <= last_slot ? '0 : pos + 1'b1;
        if (last_slot) warming_up <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Ring memory: read the oldest item on acceptance, replace it in the following cycle.
  always_ff @(posedge clk) begin
    if (in_take) begin
      old_sample <= ring[pos];
      new_sample <= sample;
    end
    if (state == ST_UPDATE) begin
      ring[pos] <= new_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) average <= quot[SAMPLE_BITS-1:0];
  end

  ama_div #(
    .NUM_BITS(SUM_BITS),
    .DEN_BITS(DEN_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (running_sum_next),
    .den  (divisor),
    .quot (quot),
    .stat (div_stat)
  );

  a_take_update: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_UPDATE)
    else $error("accepted item did not move to update");

  a_warm_stays_off: assert property (@(posedge clk) disable iff (rst)
    !warming_up |=> !warming_up)
    else $error("warm-up flag set again after the ring filled");

  a_warm_sum_bound: assert property (@(posedge clk) disable iff (rst)
    warming_up |-> 32'(running_sum) <= 32'(pos) * 32'(MAX_SAMPLE))
    else $error("running sum exceeds the samples seen during warm-up");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    32'(running_sum) <= 32'(WINDOW) * 32'(MAX_SAMPLE))
    else $error("running sum exceeds a full window");

  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire
